// ===== rtl/core/futures_symbol_root_length_unit_defines.svh =====
// Assertion macros shared by the futures symbol root length RTL.
`ifndef FUTURES_SYMBOL_ROOT_LENGTH_UNIT_DEFINES_SVH
`define FUTURES_SYMBOL_ROOT_LENGTH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FSRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsrl assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FSRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsrl assertion failed");

`endif

// ===== rtl/core/fsrl_pkg.sv =====
// Package: constants, types and helpers for the futures symbol root length unit.
`timescale 1ns / 1ps
package fsrl_pkg;

  localparam int MAX_SYMBOL_LEN = 32;
  localparam int POS_W          = $clog2(MAX_SYMBOL_LEN + 1);
  localparam int CHAR_W         = 8;
  localparam int ROOT_W         = 6;
  localparam int OUTCOME_W      = 2;

  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

  localparam logic [OUTCOME_W-1:0] OUTCOME_PLAIN  = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_MONTH  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REJECT = 2'd2;

  typedef struct packed {
    logic [ROOT_W-1:0]    root_len;
    logic [OUTCOME_W-1:0] outcome;
  } result_t;

  // Expiry month letters: F G H J K M N Q U V X Z.
  function automatic logic is_month_code(input logic [CHAR_W-1:0] c);
    logic hit;
    case (c)
      8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4D,
      8'h4E, 8'h51, 8'h55, 8'h56, 8'h58, 8'h5A: hit = 1'b1;
      default:                                  hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/core/fsrl_track.sv =====
// Per-symbol character tracker: scan state and the root length decision.
`timescale 1ns / 1ps
module fsrl_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [fsrl_pkg::CHAR_W-1:0]   sym_char,
  input  logic                          last_char,
  output fsrl_pkg::result_t             result
);

  localparam logic [fsrl_pkg::POS_W-1:0] POS_MAX = fsrl_pkg::POS_W'(fsrl_pkg::MAX_SYMBOL_LEN);

  logic [fsrl_pkg::POS_W-1:0] char_position, char_position_next;
  logic                       delimiter_seen, delimiter_seen_next;
  logic [fsrl_pkg::POS_W-1:0] effective_length, effective_length_next;
  logic [fsrl_pkg::POS_W-1:0] last_nondigit_position, last_nondigit_position_next;
  logic                       last_nondigit_is_month, last_nondigit_is_month_next;
  logic                       nondigit_seen, nondigit_seen_next;
  logic                       prev_char_is_digit, prev_char_is_digit_next;

  logic [fsrl_pkg::POS_W-1:0] pos_inc;
  logic [fsrl_pkg::POS_W-1:0] eff;
  logic [fsrl_pkg::POS_W-1:0] root;
  logic                       is_delim;
  logic                       is_digit;

  assign is_delim = (sym_char == fsrl_pkg::CH_SPACE) || (sym_char == fsrl_pkg::CH_HYPHEN);
  assign is_digit = (sym_char >= fsrl_pkg::CH_ZERO) && (sym_char <= fsrl_pkg::CH_NINE);
  assign pos_inc  = (char_position < POS_MAX) ? char_position + 1'b1 : char_position;

  // Updated scan state including the current character.
  always_comb begin
    delimiter_seen_next         = delimiter_seen;
    effective_length_next       = effective_length;
    last_nondigit_position_next = last_nondigit_position;
    last_nondigit_is_month_next = last_nondigit_is_month;
    nondigit_seen_next          = nondigit_seen;
    prev_char_is_digit_next     = prev_char_is_digit;
    char_position_next          = pos_inc;
    if (!delimiter_seen) begin
      if (is_delim) begin
        delimiter_seen_next   = 1'b1;
        effective_length_next = char_position;
      end else if (is_digit) begin
        prev_char_is_digit_next = 1'b1;
      end else begin
        prev_char_is_digit_next     = 1'b0;
        nondigit_seen_next          = 1'b1;
        last_nondigit_position_next = char_position;
        last_nondigit_is_month_next = fsrl_pkg::is_month_code(sym_char);
      end
    end
  end

  // Root decision from the updated state.
  always_comb begin
    eff = delimiter_seen_next ? effective_length_next : pos_inc;
    if ((eff == '0) || !prev_char_is_digit_next || !nondigit_seen_next) begin
      root           = eff;
      result.outcome = fsrl_pkg::OUTCOME_PLAIN;
    end else if (last_nondigit_is_month_next) begin
      root           = last_nondigit_position_next;
      result.outcome = fsrl_pkg::OUTCOME_MONTH;
    end else begin
      root           = pos_inc;
      result.outcome = fsrl_pkg::OUTCOME_REJECT;
    end
    result.root_len = fsrl_pkg::ROOT_W'(root);
  end

  // Commit on each step; clear after the final character.
  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      char_position          <= '0;
      delimiter_seen         <= 1'b0;
      effective_length       <= '0;
      last_nondigit_position <= '0;
      last_nondigit_is_month <= 1'b0;
      nondigit_seen          <= 1'b0;
      prev_char_is_digit     <= 1'b0;
    end else if (step) begin
      char_position          <= char_position_next;
      delimiter_seen         <= delimiter_seen_next;
      effective_length       <= effective_length_next;
      last_nondigit_position <= last_nondigit_position_next;
      last_nondigit_is_month <= last_nondigit_is_month_next;
      nondigit_seen          <= nondigit_seen_next;
      prev_char_is_digit     <= prev_char_is_digit_next;
    end
  end

endmodule

// ===== rtl/core/futures_symbol_root_length_unit.sv =====
// Top level: futures symbol root length unit with input and result registers.
//
//  channel | direction | tdata (low bit up)              | tlast
//  --------+-----------+---------------------------------+-----------------
//  s_*     | in        | sym_char[7:0]                   | last_char
//  m_*     | out       | root_len[5:0], outcome[7:6]     | -
//
//  One character request per cycle, sustained except while a final character waits for
//  a free result slot; the scan state update is a single compare-and-update pass between
//  the input register and the tracker. A result is registered once its final character advances.
//  rst is synchronous, active high; it clears the valid flags and scan state.
//  A stalled result blocks only the final character of the next symbol;
//  earlier characters keep flowing into the tracker.
`timescale 1ns / 1ps
`include "futures_symbol_root_length_unit_defines.svh"
module futures_symbol_root_length_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // sym_char[7:0]
  input  logic       s_tlast,   // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // root_len[5:0], outcome[7:6]
);

  // Input register stage.
  logic                            in_valid;
  logic [fsrl_pkg::CHAR_W-1:0]     in_char;
  logic                            in_last;

  // Result register stage.
  logic                            out_valid;
  logic [fsrl_pkg::ROOT_W-1:0]     out_root;
  logic [fsrl_pkg::OUTCOME_W-1:0]  out_outcome;

  logic                            out_free;
  logic                            advance;
  fsrl_pkg::result_t               result;

  // Advance a character into the tracker; a final character also needs a
  // free result slot.
  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Hold the payload until the stage advances.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  fsrl_track u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .sym_char  (in_char),
    .last_char (in_last),
    .result    (result)
  );

  // Load a result on the final character; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_root    <= result.root_len;
      out_outcome <= result.outcome;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_outcome, out_root};

  // A final character always leaves a result behind.
  `FSRL_ASSERT_NXT(a_last_gives_result, advance && in_last, out_valid)
  // An accepted request always lands in the input stage.
  `FSRL_ASSERT_NXT(a_accept_loads_stage, s_tvalid && s_tready, in_valid)
  // A rejected symbol reports its full, nonzero length.
  `FSRL_ASSERT_IMP(a_reject_nonzero,
    out_valid && (out_outcome == fsrl_pkg::OUTCOME_REJECT), out_root != '0)
  // Only defined outcome codes leave the block.
  `FSRL_ASSERT_IMP(a_outcome_defined, out_valid,
    (out_outcome == fsrl_pkg::OUTCOME_PLAIN) || (out_outcome == fsrl_pkg::OUTCOME_MONTH) ||
    (out_outcome == fsrl_pkg::OUTCOME_REJECT))

endmodule
